@@ rtl/core/ubf_pkg.sv @@
// Shared types and constants for the buffered UART TX/RX FIFO core.
package ubf_pkg;

  localparam int FIFO_DEPTH = 1024;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int LVL_W      = 11;

  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(FIFO_DEPTH);

  localparam logic [1:0] REQ_PUT   = 2'd0;
  localparam logic [1:0] REQ_EVENT = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [7:0] ERR_MASK   = 8'h0F;
  localparam int         RXNE_BIT   = 5;
  localparam int         TXE_BIT    = 7;
  localparam logic [7:0] EMPTY_READ = 8'hFF;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] tx_data;
    logic [7:0] line_flags;
    logic [7:0] rx_data;
  } in_t;

  typedef struct packed {
    logic             put_accepted;
    logic             tx_load_valid;
    logic [7:0]       tx_load_byte;
    logic [7:0]       read_byte;
    logic             read_empty;
    logic             rx_overflowed;
    logic             line_error;
    logic             sending;
    logic             tx_irq_enable;
    logic [LVL_W-1:0] tx_level;
    logic [LVL_W-1:0] rx_level;
  } out_t;

  typedef enum logic [2:0] {
    CMD_NOP  = 3'd0,
    CMD_PUT  = 3'd1,
    CMD_EVT  = 3'd2,
    CMD_LERR = 3'd3,
    CMD_READ = 3'd4
  } cmd_kind_t;

  // classified request handed from the front to the back
  typedef struct packed {
    cmd_kind_t  kind;
    logic       rx_push;
    logic       tx_done;
    logic [7:0] tx_data;
    logic [7:0] rx_data;
  } cmd_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

endpackage

@@ rtl/core/uart_buffered_tx_rx_fifos_core.sv @@
// Top level of the buffered UART TX/RX FIFO core.
//
//  channel | ports                          | moves
//  --------+--------------------------------+----------------------------
//  input   | in_valid, in_ready, in_data    | one request word (in_t)
//  result  | out_valid, out_ready, out_data | one result word (out_t)
//
// Each request executes in the back end as it leaves the two-entry request
// queue; its result is registered in the middle stage, then in the output
// stage, and appears on out_* from there.
// Sustained rate is one word per cycle while out_ready stays high.
// The registered read port of each ring RAM sets the two-stage result path.
// Synchronous active-low reset empties both FIFOs and the queue; RAM
// contents are not cleared. A stalled result holds the pipe, then the queue.
module uart_buffered_tx_rx_fifos_core import ubf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic q_valid, q_pop;
  cmd_t q_cmd;

  ubf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd)
  );

  ubf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_cmd     (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/core/ubf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ubf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/ubf_front.sv @@
// Front end: accepts request words, classifies them and queues them.
module ubf_front import ubf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic q_valid,
  input  logic q_pop,
  output cmd_t q_cmd
);

  cmd_t       slot_r [2];
  logic       wr_r, rd_r;
  logic [1:0] cnt_r;
  cmd_t       cls;
  logic       push;

  always_comb begin
    cls         = '0;
    cls.tx_data = in_data.tx_data;
    cls.rx_data = in_data.rx_data;
    cls.rx_push = in_data.line_flags[RXNE_BIT];
    cls.tx_done = in_data.line_flags[TXE_BIT];
    unique case (in_data.req_type)
      REQ_PUT:   cls.kind = CMD_PUT;
      // any error bit discards the whole event
      REQ_EVENT: cls.kind = ((in_data.line_flags & ERR_MASK) != '0) ? CMD_LERR : CMD_EVT;
      REQ_READ:  cls.kind = CMD_READ;
      default:   cls.kind = CMD_NOP;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (q_pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

@@ rtl/core/ubf_back.sv @@
// Back end: FIFO pointers, line state, ring RAMs and the result pipeline.
module ubf_back import ubf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  output logic q_pop,
  input  cmd_t q_cmd,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  typedef struct packed {
    logic             accepted;
    logic             load_valid;
    logic             bypass;
    logic [7:0]       bypass_byte;
    logic             is_read;
    logic             empty;
    logic             ovf;
    logic             lerr;
    logic             busy;
    logic             txe;
    logic [LVL_W-1:0] tx_lvl;
    logic [LVL_W-1:0] rx_lvl;
  } meta_t;

  logic [PTR_W-1:0] tx_head_r, tx_head_nxt, tx_tail_r, tx_tail_nxt;
  logic [PTR_W-1:0] rx_head_r, rx_head_nxt, rx_tail_r, rx_tail_nxt, rx_wptr;
  logic [CNT_W-1:0] tx_cnt_r, tx_cnt_nxt, rx_cnt_r, rx_cnt_nxt;
  logic             busy_r, busy_nxt, txe_r, txe_nxt;
  logic             tx_we, tx_re, rx_we, rx_re;
  logic [7:0]       tx_rdata, rx_rdata;
  meta_t            meta_nxt, b_meta_r;
  logic             b_v_r, b_move, fire;
  logic             c_v_r;
  out_t             c_data_r, c_data_nxt;

  assign b_move = b_v_r && (!c_v_r || out_ready);
  assign fire   = q_valid && (!b_v_r || b_move);
  assign q_pop  = fire;

  always_comb begin
    tx_head_nxt = tx_head_r;
    tx_tail_nxt = tx_tail_r;
    tx_cnt_nxt  = tx_cnt_r;
    rx_head_nxt = rx_head_r;
    rx_tail_nxt = rx_tail_r;
    rx_cnt_nxt  = rx_cnt_r;
    rx_wptr     = rx_head_r;
    busy_nxt    = busy_r;
    txe_nxt     = txe_r;
    tx_we       = 1'b0;
    tx_re       = 1'b0;
    rx_we       = 1'b0;
    rx_re       = 1'b0;
    meta_nxt    = '0;
    meta_nxt.bypass_byte = q_cmd.tx_data;
    unique case (q_cmd.kind)
      CMD_PUT: begin
        if (tx_cnt_r != DEPTH_CNT) begin
          tx_we             = 1'b1;
          tx_head_nxt       = ptr_inc(tx_head_r);
          meta_nxt.accepted = 1'b1;
          if (!busy_r) begin
            // idle transmitter: pop straight into the transmit register
            busy_nxt            = 1'b1;
            txe_nxt             = 1'b1;
            tx_re               = 1'b1;
            tx_tail_nxt         = ptr_inc(tx_tail_r);
            meta_nxt.load_valid = 1'b1;
            // empty FIFO: the popped word is the one written this cycle
            meta_nxt.bypass     = (tx_cnt_r == '0);
          end else begin
            tx_cnt_nxt = tx_cnt_r + CNT_W'(1);
          end
        end
      end
      CMD_EVT: begin
        if (q_cmd.rx_push) begin
          rx_we = 1'b1;
          if (rx_cnt_r == DEPTH_CNT) begin
            meta_nxt.ovf = 1'b1;
            rx_wptr      = '0;
            rx_tail_nxt  = '0;
            rx_cnt_nxt   = CNT_W'(1);
          end else begin
            rx_cnt_nxt = rx_cnt_r + CNT_W'(1);
          end
          rx_head_nxt = ptr_inc(rx_wptr);
        end
        if (q_cmd.tx_done) begin
          if (tx_cnt_r != '0) begin
            busy_nxt            = 1'b1;
            txe_nxt             = 1'b1;
            tx_re               = 1'b1;
            tx_tail_nxt         = ptr_inc(tx_tail_r);
            tx_cnt_nxt          = tx_cnt_r - CNT_W'(1);
            meta_nxt.load_valid = 1'b1;
          end else begin
            busy_nxt = 1'b0;
            txe_nxt  = 1'b0;
          end
        end
      end
      CMD_LERR: meta_nxt.lerr = 1'b1;
      CMD_READ: begin
        meta_nxt.is_read = 1'b1;
        if (rx_cnt_r == '0) begin
          meta_nxt.empty = 1'b1;
        end else begin
          rx_re       = 1'b1;
          rx_tail_nxt = ptr_inc(rx_tail_r);
          rx_cnt_nxt  = rx_cnt_r - CNT_W'(1);
        end
      end
      default: ;
    endcase
    meta_nxt.busy   = busy_nxt;
    meta_nxt.txe    = txe_nxt;
    meta_nxt.tx_lvl = LVL_W'(tx_cnt_nxt);
    meta_nxt.rx_lvl = LVL_W'(rx_cnt_nxt);
  end

  ubf_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (fire && tx_we),
    .waddr (tx_head_r),
    .wdata (q_cmd.tx_data),
    .re    (fire && tx_re),
    .raddr (tx_tail_r),
    .rdata (tx_rdata)
  );

  ubf_ram #(.WIDTH(8), .DEPTH(FIFO_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (fire && rx_we),
    .waddr (rx_wptr),
    .wdata (q_cmd.rx_data),
    .re    (fire && rx_re),
    .raddr (rx_tail_r),
    .rdata (rx_rdata)
  );

  // RAM read data is stable while the middle stage waits: no new read issues
  always_comb begin
    c_data_nxt               = '0;
    c_data_nxt.put_accepted  = b_meta_r.accepted;
    c_data_nxt.tx_load_valid = b_meta_r.load_valid;
    if (b_meta_r.load_valid) begin
      c_data_nxt.tx_load_byte = b_meta_r.bypass ? b_meta_r.bypass_byte : tx_rdata;
    end
    if (b_meta_r.is_read) begin
      c_data_nxt.read_byte = b_meta_r.empty ? EMPTY_READ : rx_rdata;
    end
    c_data_nxt.read_empty    = b_meta_r.empty;
    c_data_nxt.rx_overflowed = b_meta_r.ovf;
    c_data_nxt.line_error    = b_meta_r.lerr;
    c_data_nxt.sending       = b_meta_r.busy;
    c_data_nxt.tx_irq_enable = b_meta_r.txe;
    c_data_nxt.tx_level      = b_meta_r.tx_lvl;
    c_data_nxt.rx_level      = b_meta_r.rx_lvl;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      b_meta_r <= meta_nxt;
    end
    if (b_move) begin
      c_data_r <= c_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r <= '0;
      tx_tail_r <= '0;
      tx_cnt_r  <= '0;
      rx_head_r <= '0;
      rx_tail_r <= '0;
      rx_cnt_r  <= '0;
      busy_r    <= 1'b0;
      txe_r     <= 1'b0;
      b_v_r     <= 1'b0;
      c_v_r     <= 1'b0;
    end else begin
      if (fire) begin
        tx_head_r <= tx_head_nxt;
        tx_tail_r <= tx_tail_nxt;
        tx_cnt_r  <= tx_cnt_nxt;
        rx_head_r <= rx_head_nxt;
        rx_tail_r <= rx_tail_nxt;
        rx_cnt_r  <= rx_cnt_nxt;
        busy_r    <= busy_nxt;
        txe_r     <= txe_nxt;
      end
      b_v_r <= fire || (b_v_r && !b_move);
      c_v_r <= b_move || (c_v_r && !out_ready);
    end
  end

  assign out_valid = c_v_r;
  assign out_data  = c_data_r;

  a_tx_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tx_cnt_r <= DEPTH_CNT) else $error("tx count above depth");

  a_rx_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rx_cnt_r <= DEPTH_CNT) else $error("rx count above depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> tx_cnt_r == '0) else $error("tx idle with queued words");

  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r && !b_move |=> b_v_r && $stable(b_meta_r))
    else $error("middle stage lost or changed a word");

  a_lerr_clean: assert property (@(posedge clk) disable iff (!rst_n)
    fire && q_cmd.kind == CMD_LERR |=> !b_meta_r.ovf && !b_meta_r.load_valid)
    else $error("discarded event changed a FIFO");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the buffered UART TX/RX FIFO core.
`timescale 1ns / 1ps

module tb;
  import ubf_pkg::*;

  localparam int IDLE_PCT     = 38;
  localparam int HOLD_CYCLES  = 80;
  localparam int LIMIT_CYCLES = 400000;
  localparam int TAIL_CYCLES  = 16;
  localparam int FILL_ITEMS   = FIFO_DEPTH + 6;
  localparam int RAND_ITEMS   = 200;

  localparam logic [1:0] REQ_SPARE = 2'd3;
  localparam logic [7:0] FLAG_RXNE = 8'h01 << RXNE_BIT;
  localparam logic [7:0] FLAG_TXE  = 8'h01 << TXE_BIT;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  uart_buffered_tx_rx_fifos_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [7:0] tx_mem [FIFO_DEPTH];
  logic [7:0] rx_mem [FIFO_DEPTH];
  int   tx_wr, tx_rd, tx_cnt;
  int   rx_wr, rx_rd, rx_cnt;
  logic busy, irq_en;

  in_t  pending_reqs [$];
  out_t expected_results [$];

  int   queued_total, accepted_total, results_seen, bad_count, cycles;
  int   input_blocked, loads, rejects, overflows, line_errs, empty_reads;
  int   stall_asked, stall_seen, stall_left;
  logic calm, word_taken;

  function automatic logic tx_load(output logic [7:0] b);
    b = 8'h00;
    if (tx_cnt == 0) return 1'b0;
    busy   = 1'b1;
    b      = tx_mem[tx_rd];
    tx_rd  = (tx_rd + 1) % FIFO_DEPTH;
    tx_cnt--;
    irq_en = 1'b1;
    return 1'b1;
  endfunction

  function automatic out_t uart_step(in_t w);
    out_t r;
    logic [7:0] b;
    r = '0;
    case (w.req_type)
      REQ_PUT: begin
        if (tx_cnt < FIFO_DEPTH) begin
          tx_mem[tx_wr] = w.tx_data;
          tx_wr = (tx_wr + 1) % FIFO_DEPTH;
          tx_cnt++;
          r.put_accepted = 1'b1;
          if (!busy) begin
            busy = 1'b1;
            r.tx_load_valid = tx_load(b);
            r.tx_load_byte  = b;
          end
        end
      end
      REQ_EVENT: begin
        if ((w.line_flags & ERR_MASK) != 0) begin
          r.line_error = 1'b1;
        end else begin
          if (w.line_flags[RXNE_BIT]) begin
            // full RX ring is flushed before the new byte goes in
            if (rx_cnt >= FIFO_DEPTH) begin
              rx_cnt = 0;
              rx_wr  = 0;
              rx_rd  = 0;
              r.rx_overflowed = 1'b1;
            end
            rx_mem[rx_wr] = w.rx_data;
            rx_wr = (rx_wr + 1) % FIFO_DEPTH;
            rx_cnt++;
          end
          if (w.line_flags[TXE_BIT]) begin
            r.tx_load_valid = tx_load(b);
            r.tx_load_byte  = b;
            if (!r.tx_load_valid) begin
              busy   = 1'b0;
              irq_en = 1'b0;
            end
          end
        end
      end
      REQ_READ: begin
        if (rx_cnt == 0) begin
          r.read_byte  = EMPTY_READ;
          r.read_empty = 1'b1;
        end else begin
          r.read_byte = rx_mem[rx_rd];
          rx_rd = (rx_rd + 1) % FIFO_DEPTH;
          rx_cnt--;
        end
      end
      default: ;
    endcase
    r.sending       = busy;
    r.tx_irq_enable = irq_en;
    r.tx_level      = LVL_W'(tx_cnt);
    r.rx_level      = LVL_W'(rx_cnt);
    return r;
  endfunction

  task automatic report_bad(string what, int got, int want);
    $display("mismatch at result %0d: %s got 0x%0h want 0x%0h", results_seen, what, got, want);
    bad_count++;
  endtask

  task automatic check_result(out_t got, out_t want);
    if (got.put_accepted != want.put_accepted)
      report_bad("put_accepted", got.put_accepted, want.put_accepted);
    if (got.tx_load_valid != want.tx_load_valid)
      report_bad("tx_load_valid", got.tx_load_valid, want.tx_load_valid);
    if (got.tx_load_byte != want.tx_load_byte)
      report_bad("tx_load_byte", got.tx_load_byte, want.tx_load_byte);
    if (got.read_byte != want.read_byte)
      report_bad("read_byte", got.read_byte, want.read_byte);
    if (got.read_empty != want.read_empty)
      report_bad("read_empty", got.read_empty, want.read_empty);
    if (got.rx_overflowed != want.rx_overflowed)
      report_bad("rx_overflowed", got.rx_overflowed, want.rx_overflowed);
    if (got.line_error != want.line_error)
      report_bad("line_error", got.line_error, want.line_error);
    if (got.sending != want.sending)
      report_bad("sending", got.sending, want.sending);
    if (got.tx_irq_enable != want.tx_irq_enable)
      report_bad("tx_irq_enable", got.tx_irq_enable, want.tx_irq_enable);
    if (got.tx_level != want.tx_level)
      report_bad("tx_level", got.tx_level, want.tx_level);
    if (got.rx_level != want.rx_level)
      report_bad("rx_level", got.rx_level, want.rx_level);
  endtask

  function automatic in_t mk_req(logic [1:0] req, logic [7:0] txd, logic [7:0] flags,
                                 logic [7:0] rxd);
    in_t w;
    w.req_type   = req;
    w.tx_data    = txd;
    w.line_flags = flags;
    w.rx_data    = rxd;
    return w;
  endfunction

  function automatic void queue_req(in_t w);
    pending_reqs.push_back(w);
    queued_total++;
  endfunction

  function automatic in_t rand_req();
    in_t w;
    int  pick;
    w    = in_t'({$urandom, $urandom});
    pick = $urandom_range(99);
    if (pick < 35) begin
      w.req_type = REQ_PUT;
    end else if (pick < 70) begin
      w.req_type = REQ_EVENT;
      // mostly clean events so the FIFOs actually move
      if ($urandom_range(99) < 85) w.line_flags = w.line_flags & ~ERR_MASK;
    end else if (pick < 95) begin
      w.req_type = REQ_READ;
    end else begin
      w.req_type = REQ_SPARE;
    end
    return w;
  endfunction

  // wait at falling edges, where every count from the rising edge has settled
  task automatic drain();
    while (accepted_total != queued_total || expected_results.size() != 0)
      @(negedge clk);
    @(posedge clk);
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      word_taken = 1'b0;
    end else if (in_valid && !word_taken) begin
      // hold the word until it is taken
    end else begin
      word_taken = 1'b0;
      if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_data  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (stall_seen != stall_asked) begin
      stall_seen <= stall_seen + 1;
      stall_left <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: predicts accepted words, checks delivered results
  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = uart_step(in_data);
        expected_results.push_back(want);
        accepted_total++;
        word_taken = 1'b1;
        loads       += want.tx_load_valid;
        overflows   += want.rx_overflowed;
        line_errs   += want.line_error;
        empty_reads += want.read_empty;
        if (in_data.req_type == REQ_PUT && !want.put_accepted) rejects++;
      end
      if (in_valid && !in_ready) input_blocked++;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_bad("result with nothing expected", 1, 0);
        end else begin
          check_result(out_data, expected_results.pop_front());
        end
        results_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               expected_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    out_ready = 1'b0;
    calm = 1'b0;
    word_taken = 1'b0;
    stall_asked = 0;
    stall_seen  = 0;
    stall_left  = 0;
    queued_total = 0;
    accepted_total = 0;
    results_seen = 0;
    bad_count = 0;
    cycles = 0;
    input_blocked = 0;
    loads = 0;
    rejects = 0;
    overflows = 0;
    line_errs = 0;
    empty_reads = 0;
    tx_wr = 0; tx_rd = 0; tx_cnt = 0;
    rx_wr = 0; rx_rd = 0; rx_cnt = 0;
    busy = 1'b0;
    irq_en = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // directed: empty read, spare code, put paths, event flag combinations
    queue_req(mk_req(REQ_READ,  8'h00, 8'h00, 8'h00));
    queue_req(mk_req(REQ_SPARE, 8'hFF, 8'hFF, 8'hFF));
    queue_req(mk_req(REQ_PUT,   8'h00, 8'h00, 8'h00));
    queue_req(mk_req(REQ_PUT,   8'hFF, 8'hFF, 8'hFF));
    queue_req(mk_req(REQ_PUT,   8'hA5, 8'h00, 8'h00));
    queue_req(mk_req(REQ_EVENT, 8'h00, FLAG_TXE, 8'h33));
    queue_req(mk_req(REQ_EVENT, 8'h00, FLAG_RXNE, 8'h00));
    queue_req(mk_req(REQ_EVENT, 8'h00, FLAG_RXNE, 8'hFF));
    queue_req(mk_req(REQ_EVENT, 8'h00, FLAG_RXNE | FLAG_TXE, 8'h5A));
    queue_req(mk_req(REQ_EVENT, 8'h00, FLAG_RXNE | FLAG_TXE | 8'h01, 8'h11));
    queue_req(mk_req(REQ_EVENT, 8'h00, 8'h08, 8'h22));
    queue_req(mk_req(REQ_EVENT, 8'h00, FLAG_TXE, 8'h00));
    queue_req(mk_req(REQ_EVENT, 8'h00, FLAG_TXE, 8'h00));
    queue_req(mk_req(REQ_EVENT, 8'h00, 8'h00, 8'h00));
    queue_req(mk_req(REQ_EVENT, 8'h00, 8'h50, 8'h77));
    queue_req(mk_req(REQ_READ,  8'h00, 8'h00, 8'h00));
    queue_req(mk_req(REQ_READ,  8'h00, 8'h00, 8'h00));
    queue_req(mk_req(REQ_READ,  8'h00, 8'h00, 8'h00));
    queue_req(mk_req(REQ_READ,  8'h00, 8'h00, 8'h00));
    queue_req(mk_req(REQ_PUT,   8'h3C, 8'h00, 8'h00));
    queue_req(mk_req(REQ_EVENT, 8'h00, 8'hFF, 8'hFF));
    queue_req(mk_req(REQ_PUT,   8'h81, 8'h00, 8'h00));
    drain();

    // receiver holds off while requests keep coming: core backs up
    stall_asked++;
    repeat (60) queue_req(rand_req());
    drain();

    // no TXE events: TX ring fills and later puts are refused
    calm = 1'b1;
    repeat (FILL_ITEMS) queue_req(mk_req(REQ_PUT, 8'($urandom), 8'($urandom), 8'($urandom)));
    drain();

    // receive plus TXE: drains TX to idle, fills RX past full
    repeat (FILL_ITEMS)
      queue_req(mk_req(REQ_EVENT, 8'($urandom),
                       (FLAG_RXNE | FLAG_TXE | 8'($urandom)) & ~ERR_MASK, 8'($urandom)));
    drain();
    calm = 1'b0;

    repeat (RAND_ITEMS / 2) queue_req(rand_req());
    drain();
    stall_asked++;
    repeat (RAND_ITEMS / 2) queue_req(rand_req());
    drain();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (expected_results.size() != 0)
      report_bad("results never delivered", 0, expected_results.size());

    $display("%0d words in, %0d results checked, %0d cycles with input held off",
             accepted_total, results_seen, input_blocked);
    $display("%0d tx loads, %0d refused puts, %0d rx overflows, %0d line errors, %0d empty reads",
             loads, rejects, overflows, line_errs, empty_reads);
    if (bad_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ uart_buffered_tx_rx_fifos_core.f @@
rtl/core/ubf_pkg.sv
rtl/core/ubf_ram.sv
rtl/core/ubf_front.sv
rtl/core/ubf_back.sv
rtl/core/uart_buffered_tx_rx_fifos_core.sv
tb/tb.sv
